[design/assert_macros.svh]
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent property, checked on the rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// condition that must never be seen at a clock edge
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    `ASSERT_IMPL(label, clk, rst_n, !(cond))

`endif

[design/ssa_pkg.sv]
// types, codes and arithmetic shared by the segment sum scatter add block
`default_nettype none

package ssa_pkg;

    localparam int IDX_W   = 10;
    localparam int VAL_W   = 32;
    localparam int CMD_W   = 2;
    localparam int IDX_MAX = 2 ** IDX_W - 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_ACC   = 2'd0,
        CMD_LAST  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_WRITE = 2'd3
    } cmd_code_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_FLUSH_RD,
        S_FLUSH_WR,
        S_POST,
        S_LAST_RD,
        S_LAST_WR,
        S_READ_OUT
    } state_t;

    typedef struct packed {
        logic [CMD_W-1:0]        command;
        logic [IDX_W-1:0]        index;
        logic signed [VAL_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]        entry_index;
        logic signed [VAL_W-1:0] entry_value;
    } out_item_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load_item;
        logic run_add;
        logic run_start;
        logic run_clear;
        logic mem_rd;
        logic mem_wr;
        logic addr_item;
        logic wr_raw;
        logic add_item;
        logic out_load;
    } dp_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic [CMD_W-1:0] item_cmd;
        logic             hit;
        logic             run_open;
        logic             out_free;
    } dp_status_t;

    // signed add clamped to the q16.16 range
    function automatic logic signed [VAL_W-1:0] sat_add(
        input logic signed [VAL_W-1:0] a,
        input logic signed [VAL_W-1:0] b
    );
        logic signed [VAL_W:0] s;
        logic signed [VAL_W-1:0] r;
        s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
        if (s[VAL_W] != s[VAL_W-1]) begin
            r = s[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        end
        else begin
            r = s[VAL_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[design/ssa_stream_if.sv]
// valid/ready stream channel carrying one payload per transaction
`default_nettype none

interface ssa_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[design/segment_sum_scatter_add_unit.sv]
// top level of the segment sum scatter add block
`default_nettype none

// Segment sum with scatter-add into a result table of TABLE_DEPTH signed
// Q16.16 entries. Pairs with equal index are summed in a run accumulator;
// when the index changes, on a last-of-batch pair and before any read or
// write command the open run is added into its table entry. All adds
// saturate. Indexes are reduced modulo TABLE_DEPTH on entry. One item is in
// work at a time and the cost is set by the single-port table memory, whose
// read-modify-write of an entry is a read state followed by a write state.
// A pair that opens a new run first flushes any open run, and a read may
// also wait on the result side until the output register is free.
// The table is not cleared after reset: an entry must be written before it
// is read or added into. A read result sits in an output register, so the
// next transaction is taken while it waits to be collected.
module segment_sum_scatter_add_unit #(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    ssa_stream_if.sink   items,
    ssa_stream_if.source results
);
    import ssa_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    out_item_t  out_item;
    logic       out_valid;
    logic       in_ready;
    logic       accept;

    // input transaction taken only by the idle controller
    assign accept      = items.valid && in_ready;
    assign items.ready = in_ready;

    ssa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .status   (status),
        .cmd      (cmd),
        .in_ready (in_ready)
    );

    // table, run state and the registered result
    ssa_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .item      (items.data),
        .out_ready (results.ready),
        .status    (status),
        .out_item  (out_item),
        .out_valid (out_valid)
    );

    assign results.valid = out_valid;
    assign results.data  = out_item;

endmodule

`default_nettype wire

[design/ssa_ctrl.sv]
// sequencing state machine of the segment sum scatter add block
`default_nettype none
`include "assert_macros.svh"

module ssa_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               accept,
    input  wire ssa_pkg::dp_status_t status,
    output ssa_pkg::dp_cmd_t        cmd,
    output logic                    in_ready
);
    import ssa_pkg::*;

    state_t state_reg, state_next;
    logic   final_flush_reg, final_flush_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg       <= S_IDLE;
            final_flush_reg <= 1'b0;
        end
        else begin
            state_reg       <= state_next;
            final_flush_reg <= final_flush_next;
        end
    end

    always_comb begin
        state_next       = state_reg;
        final_flush_next = final_flush_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                final_flush_next = status.hit && (status.item_cmd == CMD_LAST);
                if (status.hit && (status.item_cmd == CMD_ACC)) begin
                    state_next = S_IDLE;
                end
                else if (status.hit && (status.item_cmd == CMD_LAST)) begin
                    state_next = S_FLUSH_RD;
                end
                else if (status.run_open) begin
                    state_next = S_FLUSH_RD;
                end
                else begin
                    state_next = S_POST;
                end
            end
            S_FLUSH_RD: state_next = S_FLUSH_WR;
            S_FLUSH_WR: begin
                final_flush_next = 1'b0;
                state_next       = final_flush_reg ? S_IDLE : S_POST;
            end
            S_POST: begin
                case (status.item_cmd)
                    CMD_ACC:  state_next = S_IDLE;
                    CMD_LAST: state_next = S_LAST_RD;
                    CMD_READ: state_next = S_READ_OUT;
                    default:  state_next = S_IDLE;
                endcase
            end
            S_LAST_RD:  state_next = S_LAST_WR;
            S_LAST_WR:  state_next = S_IDLE;
            S_READ_OUT: begin
                if (status.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE: begin
                in_ready      = 1'b1;
                cmd.load_item = accept;
            end
            S_EXEC: begin
                cmd.run_add = status.hit &&
                              ((status.item_cmd == CMD_ACC) || (status.item_cmd == CMD_LAST));
            end
            S_FLUSH_RD: cmd.mem_rd = 1'b1;
            S_FLUSH_WR: begin
                cmd.mem_wr    = 1'b1;
                cmd.run_clear = 1'b1;
            end
            S_POST: begin
                case (status.item_cmd)
                    CMD_ACC: cmd.run_start = 1'b1;
                    CMD_READ: begin
                        cmd.mem_rd    = 1'b1;
                        cmd.addr_item = 1'b1;
                    end
                    CMD_WRITE: begin
                        cmd.mem_wr    = 1'b1;
                        cmd.addr_item = 1'b1;
                        cmd.wr_raw    = 1'b1;
                    end
                    default: cmd = '0;
                endcase
            end
            S_LAST_RD: begin
                cmd.mem_rd    = 1'b1;
                cmd.addr_item = 1'b1;
            end
            S_LAST_WR: begin
                cmd.mem_wr    = 1'b1;
                cmd.addr_item = 1'b1;
                cmd.add_item  = 1'b1;
            end
            S_READ_OUT: cmd.out_load = status.out_free;
            default:    cmd = '0;
        endcase
    end

    `ASSERT_IMPL(a_accept_to_exec, clk, rst_n, accept |=> state_reg == S_EXEC)
    `ASSERT_NEVER(a_flag_not_idle, clk, rst_n, final_flush_reg && state_reg == S_IDLE)

endmodule

`default_nettype wire

[design/ssa_datapath.sv]
// run accumulator, item registers, result table and output register
`default_nettype none
`include "assert_macros.svh"

module ssa_datapath #(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ssa_pkg::dp_cmd_t    cmd,
    input  wire ssa_pkg::in_item_t   item,
    input  wire logic                out_ready,
    output ssa_pkg::dp_status_t      status,
    output ssa_pkg::out_item_t       out_item,
    output logic                     out_valid
);
    import ssa_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);

    // conditional subtractions of depth times a power of two
    function automatic int mod_steps(input int depth);
        int n;
        n = 0;
        while ((depth << n) <= IDX_MAX) begin
            n++;
        end
        return n;
    endfunction

    localparam int MOD_STEPS = mod_steps(TABLE_DEPTH);

    function automatic logic [IDX_W-1:0] reduce_index(input logic [IDX_W-1:0] raw);
        logic [IDX_W-1:0] r;
        r = raw;
        for (int k = MOD_STEPS - 1; k >= 0; k--) begin
            if (r >= IDX_W'(TABLE_DEPTH << k)) begin
                r = r - IDX_W'(TABLE_DEPTH << k);
            end
        end
        return r;
    endfunction

    logic [CMD_W-1:0]        item_cmd_reg;
    logic [IDX_W-1:0]        item_idx_reg;
    logic signed [VAL_W-1:0] item_val_reg;
    logic signed [VAL_W-1:0] run_sum_reg;
    logic [IDX_W-1:0]        run_index_reg;
    logic                    run_open_reg;
    logic signed [VAL_W-1:0] mem_rdata_reg;
    logic                    out_valid_reg;
    out_item_t               out_item_reg;

    logic signed [VAL_W-1:0] table_mem [TABLE_DEPTH];

    logic [ADDR_W-1:0]       mem_addr;
    logic signed [VAL_W-1:0] add_operand;
    logic signed [VAL_W-1:0] mem_wdata;

    always_ff @(posedge clk) begin
        if (cmd.load_item) begin
            item_cmd_reg <= item.command;
            item_idx_reg <= reduce_index(item.index);
            item_val_reg <= item.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            run_sum_reg   <= '0;
            run_index_reg <= '0;
            run_open_reg  <= 1'b0;
        end
        else if (cmd.run_add) begin
            run_sum_reg <= sat_add(run_sum_reg, item_val_reg);
        end
        else if (cmd.run_start) begin
            run_sum_reg   <= item_val_reg;
            run_index_reg <= item_idx_reg;
            run_open_reg  <= 1'b1;
        end
        else if (cmd.run_clear) begin
            run_sum_reg  <= '0;
            run_open_reg <= 1'b0;
        end
    end

    assign mem_addr    = cmd.addr_item ? ADDR_W'(item_idx_reg) : ADDR_W'(run_index_reg);
    assign add_operand = cmd.add_item ? item_val_reg : run_sum_reg;
    assign mem_wdata   = cmd.wr_raw ? item_val_reg : sat_add(mem_rdata_reg, add_operand);

    always_ff @(posedge clk) begin
        if (cmd.mem_wr) begin
            table_mem[mem_addr] <= mem_wdata;
        end
        if (cmd.mem_rd) begin
            mem_rdata_reg <= table_mem[mem_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.out_load) begin
            out_item_reg.entry_index <= item_idx_reg;
            out_item_reg.entry_value <= mem_rdata_reg;
        end
    end

    assign status.item_cmd = item_cmd_reg;
    assign status.hit      = run_open_reg && (item_idx_reg == run_index_reg);
    assign status.run_open = run_open_reg;
    assign status.out_free = !out_valid_reg || out_ready;
    assign out_item        = out_item_reg;
    assign out_valid       = out_valid_reg;

    `ASSERT_NEVER(a_single_port, clk, rst_n, cmd.mem_rd && cmd.mem_wr)
    `ASSERT_NEVER(a_add_needs_run, clk, rst_n, cmd.run_add && !run_open_reg)
    `ASSERT_NEVER(a_no_overwrite, clk, rst_n, cmd.out_load && out_valid_reg && !out_ready)

endmodule

`default_nettype wire

[tb/testbench.sv]
// self-checking testbench for the segment sum scatter add unit
`default_nettype none

module testbench;

    import ssa_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int DEPTH         = 1024;
    localparam int ITEM_TARGET   = 1450;
    // the last stretch of the run goes with no idling on either side
    localparam int CALM_FROM     = ITEM_TARGET - 150;
    // longest correct quiet spell is a slow read behind a full output stall
    localparam int QUIET_LIMIT   = 1000;
    localparam int DRAIN_CYCLES  = 16;
    localparam int DIRECTED_ROWS = 26;

    localparam logic [VAL_W-1:0] Q_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] Q_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    // one row of the directed table; want only counts where known is set
    typedef struct packed {
        cmd_code_t        cmd;
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] val;
        logic             known;
        logic [VAL_W-1:0] want;
    } stim_row_t;

    logic clk;
    logic rst_n;

    ssa_stream_if #(.payload_t(in_item_t))  items_ch ();
    ssa_stream_if #(.payload_t(out_item_t)) results_ch ();

    segment_sum_scatter_add_unit #(
        .TABLE_DEPTH(DEPTH)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items_ch),
        .results (results_ch)
    );

    // ------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
    end

    always #(HALF_PERIOD) clk = ~clk;

    // ------------------------------------------------------------------
    // shadow of the block: table contents, which entries hold data, and
    // the open run of equal indexes
    // ------------------------------------------------------------------
    logic signed [VAL_W-1:0] entry_model [DEPTH];
    bit                      entry_known [DEPTH];
    int unsigned             known_slots [$];
    logic signed [VAL_W-1:0] run_total;
    int unsigned             run_slot;
    bit                      run_live;

    // reads still to come back from the block, oldest first
    out_item_t pending_reads [$];

    int  mismatches;
    int  sent_count;
    bit  idle_on;

    // q16.16 add clamped at both ends of the range
    function automatic logic signed [VAL_W-1:0] q_sat_add(
        input logic signed [VAL_W-1:0] a,
        input logic signed [VAL_W-1:0] b
    );
        longint wide;
        wide = longint'(a) + longint'(b);
        if (wide > longint'($signed(Q_MAX)))
            return Q_MAX;
        if (wide < longint'($signed(Q_MIN)))
            return Q_MIN;
        return wide[VAL_W-1:0];
    endfunction

    // close the open run by adding its sum into its entry
    function automatic void fold_run();
        if (run_live)
        begin
            entry_model[run_slot] = q_sat_add(entry_model[run_slot], run_total);
            run_live  = 1'b0;
            run_total = '0;
        end
    endfunction

    // extend the open run, or close it and start a new one
    function automatic void add_pair(input int unsigned slot, input logic [VAL_W-1:0] val);
        if (run_live && slot == run_slot)
        begin
            run_total = q_sat_add(run_total, val);
        end
        else
        begin
            fold_run();
            run_live  = 1'b1;
            run_slot  = slot;
            run_total = val;
        end
    endfunction

    // advance the shadow by one accepted transaction and say what comes back
    function automatic void apply_scatter_add(
        input  in_item_t  it,
        output bit        has_entry,
        output out_item_t entry
    );
        int unsigned slot;
        slot      = it.index % DEPTH;
        has_entry = 1'b0;
        entry     = '0;
        case (cmd_code_t'(it.command))
            CMD_ACC:
            begin
                add_pair(slot, it.value);
            end
            CMD_LAST:
            begin
                add_pair(slot, it.value);
                fold_run();
            end
            CMD_READ:
            begin
                fold_run();
                has_entry         = 1'b1;
                entry.entry_index = slot[IDX_W-1:0];
                entry.entry_value = entry_model[slot];
            end
            default:
            begin
                fold_run();
                entry_model[slot] = it.value;
                if (!entry_known[slot])
                begin
                    entry_known[slot] = 1'b1;
                    known_slots.push_back(slot);
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic in_item_t make_item(
        input cmd_code_t        c,
        input logic [IDX_W-1:0] i,
        input logic [VAL_W-1:0] v
    );
        in_item_t it;
        it.command = c;
        it.index   = i;
        it.value   = v;
        return it;
    endfunction

    // only entries already holding data may be read or added into
    function automatic logic [IDX_W-1:0] pick_known();
        return IDX_W'(known_slots[$urandom_range(0, known_slots.size() - 1)]);
    endfunction

    // mostly small fractions, with extremes and full-width noise mixed in
    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2, 3:    return $urandom;
            default: return $urandom_range(0, 32'h3FFFF) - 32'h20000;
        endcase
    endfunction

    // present one transaction, wait for it to be taken and update the shadow;
    // a directed read may carry its expected contents typed in
    task automatic drive_transaction(
        input in_item_t         it,
        input bit               typed,
        input logic [VAL_W-1:0] typed_value
    );
        bit        has_entry;
        out_item_t entry;
        if (sent_count >= CALM_FROM)
            idle_on = 1'b0;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            items_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        items_ch.valid <= 1'b1;
        items_ch.data  <= it;
        do
            @(posedge clk);
        while (!items_ch.ready);
        apply_scatter_add(it, has_entry, entry);
        if (has_entry)
        begin
            if (typed)
                entry.entry_value = typed_value;
            pending_reads.push_back(entry);
        end
        sent_count++;
        @(negedge clk);
    endtask

    task automatic send(input cmd_code_t c, input logic [IDX_W-1:0] i, input logic [VAL_W-1:0] v);
        drive_transaction(make_item(c, i, v), 1'b0, '0);
    endtask

    // ------------------------------------------------------------------
    // directed table: extremes, every command, saturation in the run and
    // in the table, index change, last of batch with no open run, and a
    // read or write that flushes an open run
    // ------------------------------------------------------------------
    stim_row_t directed [DIRECTED_ROWS] = '{
        '{CMD_WRITE, 10'd0,     32'h7FFF_FFFF, 1'b0, 32'h0},
        '{CMD_READ,  10'd0,     32'h0,         1'b1, 32'h7FFF_FFFF},
        '{CMD_WRITE, 10'd1023,  32'h8000_0000, 1'b0, 32'h0},
        '{CMD_READ,  10'd1023,  32'h0,         1'b1, 32'h8000_0000},
        // positive saturation, first in the run and then in the table
        '{CMD_ACC,   10'd0,     32'h0000_0001, 1'b0, 32'h0},
        '{CMD_LAST,  10'd0,     32'h7FFF_FFFF, 1'b0, 32'h0},
        '{CMD_READ,  10'd0,     32'h0,         1'b1, 32'h7FFF_FFFF},
        // negative saturation, flushed by the change of index
        '{CMD_ACC,   10'd1023,  32'hFFFF_FFFF, 1'b0, 32'h0},
        '{CMD_ACC,   10'd1023,  32'h8000_0000, 1'b0, 32'h0},
        '{CMD_ACC,   10'd0,     32'h8000_0000, 1'b0, 32'h0},
        '{CMD_READ,  10'd1023,  32'h0,         1'b1, 32'h8000_0000},
        '{CMD_READ,  10'd0,     32'h0,         1'b1, 32'hFFFF_FFFF},
        // run of one index closed by a read
        '{CMD_WRITE, 10'h155,   32'h0001_0000, 1'b0, 32'h0},
        '{CMD_ACC,   10'h155,   32'h0000_8000, 1'b0, 32'h0},
        '{CMD_ACC,   10'h155,   32'h0000_8000, 1'b0, 32'h0},
        '{CMD_READ,  10'h155,   32'h0,         1'b0, 32'h0},
        // last of batch with nothing open goes straight into the table
        '{CMD_WRITE, 10'h2AA,   32'h1234_5678, 1'b0, 32'h0},
        '{CMD_LAST,  10'h2AA,   32'h0000_0010, 1'b0, 32'h0},
        '{CMD_READ,  10'h2AA,   32'h0,         1'b0, 32'h0},
        // two runs in one batch
        '{CMD_ACC,   10'h155,   32'h0000_0003, 1'b0, 32'h0},
        '{CMD_ACC,   10'h2AA,   32'h0000_0004, 1'b0, 32'h0},
        '{CMD_LAST,  10'h2AA,   32'h0000_0005, 1'b0, 32'h0},
        // open run flushed by a write, which then overwrites the entry
        '{CMD_ACC,   10'h155,   32'h0000_0007, 1'b0, 32'h0},
        '{CMD_WRITE, 10'h155,   32'hDEAD_BEEF, 1'b0, 32'h0},
        '{CMD_READ,  10'h155,   32'h0,         1'b1, 32'hDEAD_BEEF},
        '{CMD_READ,  10'h2AA,   32'h0,         1'b0, 32'h0}
    };

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned      slots [$];
        int unsigned      reps;
        int unsigned      lead;
        logic [IDX_W-1:0] hot;

        rst_n          = 1'b0;
        items_ch.valid = 1'b0;
        items_ch.data  = '0;
        mismatches     = 0;
        sent_count     = 0;
        idle_on        = 1'b1;
        run_total      = '0;
        run_slot       = 0;
        run_live       = 1'b0;
        foreach (entry_model[i])
        begin
            entry_model[i] = '0;
            entry_known[i] = 1'b0;
        end

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed[r])
            drive_transaction(make_item(directed[r].cmd, directed[r].idx, directed[r].val),
                              directed[r].known, directed[r].want);

        // random part: mostly sorted batches, with noise and broken batches
        while (sent_count < ITEM_TARGET)
        begin
            case ($urandom_range(0, 11))
                0, 1, 2, 3:
                begin
                    // well-formed batch: ascending indexes, each a run of pairs,
                    // the very last pair marked last of batch
                    slots.delete();
                    repeat ($urandom_range(1, 4)) slots.push_back(pick_known());
                    slots.sort();
                    foreach (slots[s])
                    begin
                        reps = $urandom_range(1, 4);
                        for (int r = 0; r < reps; r++)
                            send(cmd_code_t'((s == slots.size() - 1 && r == reps - 1) ?
                                             CMD_LAST : CMD_ACC),
                                 IDX_W'(slots[s]), pick_value());
                    end
                end
                4, 5:
                begin
                    // any index, so the set of loaded entries keeps growing
                    send(CMD_WRITE, IDX_W'($urandom_range(0, IDX_MAX)), pick_value());
                end
                6, 7:
                begin
                    send(CMD_READ, pick_known(), $urandom);
                end
                8:
                begin
                    // unsorted pairs with no batch end
                    repeat ($urandom_range(1, 4)) send(CMD_ACC, pick_known(), pick_value());
                end
                9:
                begin
                    send(CMD_LAST, pick_known(), pick_value());
                end
                10:
                begin
                    // batch cut short by an access to the same or another entry
                    hot = pick_known();
                    repeat ($urandom_range(1, 3)) send(CMD_ACC, hot, pick_value());
                    lead = $urandom_range(0, 1);
                    if (lead == 0)
                        send(CMD_READ, ($urandom_range(0, 1) == 0) ? hot : pick_known(), $urandom);
                    else
                        send(CMD_WRITE, ($urandom_range(0, 1) == 0) ? hot : pick_known(),
                             pick_value());
                end
                default:
                begin
                    // back to back reads of one entry; only the first can find a run to flush
                    hot = pick_known();
                    repeat ($urandom_range(2, 3)) send(CMD_READ, hot, $urandom);
                end
            endcase
        end

        items_ch.valid <= 1'b0;
        while (pending_reads.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("** segment_sum_scatter_add_unit: PASSED **");
        else
            $display("** segment_sum_scatter_add_unit: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // result side: ready drops at random while idling is on
    // ------------------------------------------------------------------
    initial
    begin
        int stall_left;
        stall_left       = 0;
        results_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (idle_on && stall_left == 0 && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 3);
            if (stall_left > 0)
            begin
                results_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                results_ch.ready <= 1'b1;
            end
        end
    end

    // every read transaction is compared with the oldest outstanding read
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && results_ch.valid && results_ch.ready)
        begin
            if (pending_reads.size() == 0)
            begin
                $error("entry_index: expected no result, actual %0d", results_ch.data.entry_index);
                mismatches++;
            end
            else
            begin
                want = pending_reads.pop_front();
                if (results_ch.data.entry_index !== want.entry_index)
                begin
                    $error("entry_index: expected %0d, actual %0d",
                           want.entry_index, results_ch.data.entry_index);
                    mismatches++;
                end
                if (results_ch.data.entry_value !== want.entry_value)
                begin
                    $error("entry_value: expected %h, actual %h",
                           want.entry_value, results_ch.data.entry_value);
                    mismatches++;
                end
            end
        end
    end

    // watchdog: too long with no transaction on either channel
    always @(posedge clk)
    begin
        int quiet;
        if (rst_n)
        begin
            if ((items_ch.valid && items_ch.ready) || (results_ch.valid && results_ch.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("** segment_sum_scatter_add_unit: FAILED **");
                $finish;
            end
        end
        else
        begin
            quiet = 0;
        end
    end

endmodule

`default_nettype wire
